// ----- hdl/i2cmw_pkg.sv -----
package i2cmw_pkg;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] REG_PHASE_TICKS = 2'd1;
  localparam logic [1:0] REG_ACK_LIMIT   = 2'd2;

  localparam logic [6:0]  DEV_ADDR_RST    = 7'd60;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd250;
  localparam logic [7:0]  ACK_LIMIT_RST   = 8'd250;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] phase_ticks;
    logic [7:0]  ack_limit;
  } cfg_t;

  typedef struct packed {
    logic       byte_offered;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic       sda_sampled;
  } item_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic byte_taken;
    logic busy_res;
    logic nack_error;
    logic done_res;
  } res_t;

endpackage

// ----- hdl/i2cmw_regs.sv -----
module i2cmw_regs
  import i2cmw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr    <= DEV_ADDR_RST;
      cfg_r.phase_ticks <= PHASE_TICKS_RST;
      cfg_r.ack_limit   <= ACK_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEV_ADDR:    cfg_r.dev_addr    <= pwdata[6:0];
        REG_PHASE_TICKS: cfg_r.phase_ticks <= pwdata[15:0];
        REG_ACK_LIMIT:   cfg_r.ack_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEV_ADDR:    prdata = {{(APB_DW-7){1'b0}}, cfg_r.dev_addr};
      REG_PHASE_TICKS: prdata = {{(APB_DW-16){1'b0}}, cfg_r.phase_ticks};
      REG_ACK_LIMIT:   prdata = {{(APB_DW-8){1'b0}}, cfg_r.ack_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hdl/i2cmw_seq.sv -----
module i2cmw_seq
  import i2cmw_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
    PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW,
    PH_ACK_SETUP, PH_ACK_POLL, PH_ACK_LOW, PH_WAIT,
    PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  localparam int LW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [2:0]             bit_cnt_r, bit_cnt_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             ack_cnt_r, ack_cnt_nxt;
  logic                   last_pend_r, last_pend_nxt;
  logic                   abort_r, abort_nxt;
  logic                   addr_sent_r, addr_sent_nxt;

  logic [LW-1:0] len_raw, len_cap, len_eff, timer_plus;
  logic          elapsed;
  logic [7:0]    ack_inc, ack_lim;
  logic          cur_bit;

  // phase length: zero means one tick, saturates at the timer range
  always_comb begin
    len_raw    = (cfg.phase_ticks == 16'd0) ? LW'(1)
                 : {{(LW-16){1'b0}}, cfg.phase_ticks};
    len_cap    = LW'(1) << TIMER_WIDTH;
    len_eff    = (len_raw > len_cap) ? len_cap : len_raw;
    timer_plus = {{(LW-TIMER_WIDTH){1'b0}}, timer_r} + LW'(1);
    elapsed    = (timer_plus >= len_eff);
  end

  assign cur_bit = shift_r[7];
  assign ack_inc = ack_cnt_r + 8'd1;
  assign ack_lim = (cfg.ack_limit == 8'd0) ? 8'd1 : cfg.ack_limit;

  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = elapsed ? '0 : timer_r + 1'b1;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    ack_cnt_nxt   = ack_cnt_r;
    last_pend_nxt = last_pend_r;
    abort_nxt     = abort_r;
    addr_sent_nxt = addr_sent_r;
    res           = '0;
    res.scl_release = 1'b1;
    res.sda_release = 1'b1;

    // line levels reflect the phase held at the start of the tick
    unique case (phase_r)
      PH_START_B:   res.sda_release = 1'b0;
      PH_START_C, PH_STOP_A: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
      end
      PH_BIT_SETUP, PH_BIT_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = cur_bit;
      end
      PH_BIT_HIGH:  res.sda_release = cur_bit;
      PH_ACK_SETUP, PH_ACK_LOW, PH_WAIT: res.scl_release = 1'b0;
      PH_STOP_B:    res.sda_release = 1'b0;
      default: ;
    endcase

    unique case (phase_r)
      PH_IDLE: begin
        timer_nxt = '0;
        if (abort_r) begin
          if (item.byte_offered) begin
            res.byte_taken = 1'b1;
            if (item.payload_last) abort_nxt = 1'b0;
          end
        end else if (item.byte_offered) begin
          shift_nxt     = {cfg.dev_addr, 1'b0};
          bit_cnt_nxt   = '0;
          ack_cnt_nxt   = '0;
          last_pend_nxt = 1'b0;
          addr_sent_nxt = 1'b0;
          phase_nxt     = PH_START_A;
        end
      end
      PH_START_A:   if (elapsed) phase_nxt = PH_START_B;
      PH_START_B:   if (elapsed) phase_nxt = PH_START_C;
      PH_START_C:   if (elapsed) phase_nxt = PH_BIT_SETUP;
      PH_BIT_SETUP: if (elapsed) phase_nxt = PH_BIT_HIGH;
      PH_BIT_HIGH:  if (elapsed) phase_nxt = PH_BIT_LOW;
      PH_BIT_LOW: begin
        if (elapsed) begin
          if (bit_cnt_r == 3'd7) begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_ACK_SETUP;
          end else begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = PH_BIT_SETUP;
          end
        end
      end
      PH_ACK_SETUP: begin
        if (elapsed) begin
          ack_cnt_nxt = '0;
          phase_nxt   = PH_ACK_POLL;
        end
      end
      PH_ACK_POLL: begin
        timer_nxt = '0;
        if (!item.sda_sampled) begin
          ack_cnt_nxt = '0;
          phase_nxt   = PH_ACK_LOW;
        end else if (ack_inc >= ack_lim) begin
          ack_cnt_nxt    = '0;
          res.nack_error = 1'b1;
          abort_nxt      = !(addr_sent_r && last_pend_r);
          phase_nxt      = PH_STOP_A;
        end else begin
          ack_cnt_nxt = ack_inc;
        end
      end
      PH_ACK_LOW: begin
        if (elapsed) begin
          if (addr_sent_r && last_pend_r) begin
            phase_nxt = PH_STOP_A;
          end else begin
            addr_sent_nxt = 1'b1;
            phase_nxt     = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        timer_nxt = '0;
        if (item.byte_offered) begin
          res.byte_taken = 1'b1;
          shift_nxt      = item.payload_byte;
          last_pend_nxt  = item.payload_last;
          bit_cnt_nxt    = '0;
          phase_nxt      = PH_BIT_SETUP;
        end
      end
      PH_STOP_A: if (elapsed) phase_nxt = PH_STOP_B;
      PH_STOP_B: if (elapsed) phase_nxt = PH_STOP_C;
      PH_STOP_C: begin
        if (elapsed) begin
          res.done_res  = 1'b1;
          last_pend_nxt = 1'b0;
          addr_sent_nxt = 1'b0;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        timer_nxt = '0;
        phase_nxt = PH_IDLE;
      end
    endcase

    res.busy_res = (phase_nxt != PH_IDLE) || abort_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      ack_cnt_r   <= '0;
      last_pend_r <= 1'b0;
      abort_r     <= 1'b0;
      addr_sent_r <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      ack_cnt_r   <= ack_cnt_nxt;
      last_pend_r <= last_pend_nxt;
      abort_r     <= abort_nxt;
      addr_sent_r <= addr_sent_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |=> phase_r == PH_IDLE)
    else $error("done pulse without return to idle");

  a_nack_to_stop: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.nack_error |=> phase_r == PH_STOP_A)
    else $error("nack without stop");

  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(shift_r))
    else $error("sequencer moved without a transfer");

  a_wait_bitcnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT |-> bit_cnt_r == 3'd0 && addr_sent_r)
    else $error("byte wait with stale bit count");
`endif

endmodule

// ----- hdl/i2c_master_write_engine.sv -----
// Write-only I2C master. Each input transfer is one tick of the bus sequencer and yields
// exactly one result transfer carrying the SCL/SDA release levels and the status pulses
// for that tick. One transfer is accepted per cycle while the result side keeps up; an input
// register and a result register sit on either side of the sequencer step, and a stalled
// result side stops input only once both registers are full. Bus timing is counted in ticks:
// phase_ticks per start, stop and bit phase, and up to ack_limit SDA samples for the
// acknowledge. After a NACK the remaining bytes up to the one marked last are taken and
// discarded. Write configuration only while idle.
module i2c_master_write_engine
  import i2cmw_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_byte_offered,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_payload_last,
  input  logic              in_sda_sampled,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_scl_release,
  output logic              out_sda_release,
  output logic              out_byte_taken,
  output logic              out_busy_res,
  output logic              out_nack_error,
  output logic              out_done_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  item_t in_item_r;
  logic  in_vld_r;
  res_t  step_res;
  res_t  out_res_r;
  logic  out_vld_r;
  logic  step_en;
  logic  in_xfer;

  i2cmw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign step_en  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_en;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_xfer || (in_vld_r && !step_en);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.byte_offered <= in_byte_offered;
      in_item_r.payload_byte <= in_payload_byte;
      in_item_r.payload_last <= in_payload_last;
      in_item_r.sda_sampled  <= in_sda_sampled;
    end
  end

  i2cmw_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= step_en || (out_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_scl_release = out_res_r.scl_release;
  assign out_sda_release = out_res_r.sda_release;
  assign out_byte_taken  = out_res_r.byte_taken;
  assign out_busy_res    = out_res_r.busy_res;
  assign out_nack_error  = out_res_r.nack_error;
  assign out_done_res    = out_res_r.done_res;

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import i2cmw_pkg::*;

  localparam int TMR_W = 16;
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START_A, BUS_START_B, BUS_START_C,
    BUS_BIT_SETUP, BUS_BIT_HIGH, BUS_BIT_LOW,
    BUS_ACK_SETUP, BUS_ACK_POLL, BUS_ACK_LOW, BUS_WAIT,
    BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
  } bus_phase_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_byte_offered;
  logic [7:0]        in_payload_byte;
  logic              in_payload_last;
  logic              in_sda_sampled;
  logic              out_valid;
  logic              out_ready;
  logic              out_scl_release;
  logic              out_sda_release;
  logic              out_byte_taken;
  logic              out_busy_res;
  logic              out_nack_error;
  logic              out_done_res;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  i2c_master_write_engine #(.TIMER_WIDTH(TMR_W)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_offered (in_byte_offered),
    .in_payload_byte (in_payload_byte),
    .in_payload_last (in_payload_last),
    .in_sda_sampled  (in_sda_sampled),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scl_release (out_scl_release),
    .out_sda_release (out_sda_release),
    .out_byte_taken  (out_byte_taken),
    .out_busy_res    (out_busy_res),
    .out_nack_error  (out_nack_error),
    .out_done_res    (out_done_res),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // bus sequencer mirror
  logic [6:0]        cur_dev_addr = DEV_ADDR_RST;
  logic [15:0]       cur_phase_ticks = PHASE_TICKS_RST;
  logic [7:0]        cur_ack_limit = ACK_LIMIT_RST;
  bus_phase_t        bus_ph = BUS_IDLE;
  longint unsigned   ph_timer = 0;
  logic [2:0]        bit_cnt = '0;
  logic [7:0]        shift_q = '0;
  logic [7:0]        ack_cnt = '0;
  logic              last_flag = 1'b0;
  logic              abort_flag = 1'b0;
  logic              addr_done = 1'b0;

  res_t expected_levels[$];
  int   error_count = 0;
  int   result_count = 0;
  int   tick_count = 0;
  int   quiet_cycles = 0;
  int   hold_req = 0;
  int   rx_stall = 0;
  bit   tx_gaps_on = 1'b1;
  bit   rx_stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void enter_phase(bus_phase_t p);
    bus_ph = p;
    ph_timer = 0;
  endfunction

  // advances the phase timer, true on the last tick of the phase
  function automatic bit phase_done();
    longint unsigned len;
    len = (cur_phase_ticks == 0) ? 1 : cur_phase_ticks;
    if (len > (64'd1 << TMR_W)) len = 64'd1 << TMR_W;
    if (ph_timer + 1 >= len) begin
      ph_timer = 0;
      return 1'b1;
    end
    ph_timer = (ph_timer + 1) & ((64'd1 << TMR_W) - 1);
    return 1'b0;
  endfunction

  function automatic res_t predict_tick(item_t it);
    res_t r;
    logic msb;
    logic [7:0] lim;
    msb = shift_q[7];
    lim = (cur_ack_limit == 0) ? 8'd1 : cur_ack_limit;
    r = '0;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    // line levels reflect the phase held at the start of the tick
    case (bus_ph)
      BUS_START_B, BUS_STOP_B: r.sda_release = 1'b0;
      BUS_START_C, BUS_STOP_A: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
      end
      BUS_BIT_SETUP, BUS_BIT_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = msb;
      end
      BUS_BIT_HIGH: r.sda_release = msb;
      BUS_ACK_SETUP, BUS_ACK_LOW, BUS_WAIT: r.scl_release = 1'b0;
      default: ;
    endcase

    case (bus_ph)
      BUS_IDLE: begin
        if (abort_flag) begin
          if (it.byte_offered) begin
            r.byte_taken = 1'b1;
            if (it.payload_last) abort_flag = 1'b0;
          end
        end else if (it.byte_offered) begin
          shift_q = {cur_dev_addr, 1'b0};
          bit_cnt = '0;
          ack_cnt = '0;
          last_flag = 1'b0;
          addr_done = 1'b0;
          enter_phase(BUS_START_A);
        end
      end
      BUS_START_A: if (phase_done()) enter_phase(BUS_START_B);
      BUS_START_B: if (phase_done()) enter_phase(BUS_START_C);
      BUS_START_C: if (phase_done()) enter_phase(BUS_BIT_SETUP);
      BUS_BIT_SETUP: if (phase_done()) enter_phase(BUS_BIT_HIGH);
      BUS_BIT_HIGH: if (phase_done()) enter_phase(BUS_BIT_LOW);
      BUS_BIT_LOW: begin
        if (phase_done()) begin
          if (bit_cnt == 3'd7) begin
            bit_cnt = '0;
            enter_phase(BUS_ACK_SETUP);
          end else begin
            shift_q = shift_q << 1;
            bit_cnt = bit_cnt + 3'd1;
            enter_phase(BUS_BIT_SETUP);
          end
        end
      end
      BUS_ACK_SETUP: begin
        if (phase_done()) begin
          ack_cnt = '0;
          enter_phase(BUS_ACK_POLL);
        end
      end
      BUS_ACK_POLL: begin
        if (!it.sda_sampled) begin
          ack_cnt = '0;
          enter_phase(BUS_ACK_LOW);
        end else begin
          ack_cnt = ack_cnt + 8'd1;
          if (ack_cnt >= lim) begin
            ack_cnt = '0;
            r.nack_error = 1'b1;
            abort_flag = !(addr_done && last_flag);
            enter_phase(BUS_STOP_A);
          end
        end
      end
      BUS_ACK_LOW: begin
        if (phase_done()) begin
          if (addr_done && last_flag) begin
            enter_phase(BUS_STOP_A);
          end else begin
            addr_done = 1'b1;
            enter_phase(BUS_WAIT);
          end
        end
      end
      BUS_WAIT: begin
        if (it.byte_offered) begin
          r.byte_taken = 1'b1;
          shift_q = it.payload_byte;
          last_flag = it.payload_last;
          bit_cnt = '0;
          enter_phase(BUS_BIT_SETUP);
        end
      end
      BUS_STOP_A: if (phase_done()) enter_phase(BUS_STOP_B);
      BUS_STOP_B: if (phase_done()) enter_phase(BUS_STOP_C);
      BUS_STOP_C: begin
        if (phase_done()) begin
          r.done_res = 1'b1;
          last_flag = 1'b0;
          addr_done = 1'b0;
          enter_phase(BUS_IDLE);
        end
      end
      default: enter_phase(BUS_IDLE);
    endcase
    r.busy_res = (bus_ph != BUS_IDLE) || abort_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("mismatch on result %0d: %s got %b want %b", result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_levels();
    res_t want;
    if (expected_levels.size() == 0) begin
      report_mismatch("transfer with nothing expected", 1'b1, 1'b0);
      return;
    end
    want = expected_levels.pop_front();
    if (out_scl_release !== want.scl_release)
      report_mismatch("scl_release", out_scl_release, want.scl_release);
    if (out_sda_release !== want.sda_release)
      report_mismatch("sda_release", out_sda_release, want.sda_release);
    if (out_byte_taken !== want.byte_taken)
      report_mismatch("byte_taken", out_byte_taken, want.byte_taken);
    if (out_busy_res !== want.busy_res)
      report_mismatch("busy_res", out_busy_res, want.busy_res);
    if (out_nack_error !== want.nack_error)
      report_mismatch("nack_error", out_nack_error, want.nack_error);
    if (out_done_res !== want.done_res)
      report_mismatch("done_res", out_done_res, want.done_res);
    result_count++;
  endtask

  // result side: check, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_levels();
    if (hold_req > 0) begin
      rx_stall = hold_req;
      hold_req = 0;
    end else if (rx_stall == 0 && rx_stalls_on && $urandom_range(0, 5) == 0) begin
      rx_stall = pick_gap();
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_tick(input item_t it);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_offered <= it.byte_offered;
    in_payload_byte <= it.payload_byte;
    in_payload_last <= it.payload_last;
    in_sda_sampled <= it.sda_sampled;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(predict_tick(it));
    tick_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_DEV_ADDR:    cur_dev_addr = value[6:0];
      REG_PHASE_TICKS: cur_phase_ticks = value[15:0];
      REG_ACK_LIMIT:   cur_ack_limit = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int addr, input int ticks, input int limit);
    cfg_write(REG_DEV_ADDR, addr);
    cfg_write(REG_PHASE_TICKS, ticks);
    cfg_write(REG_ACK_LIMIT, limit);
  endtask

  // one write transfer of nbytes; nack_at picks the ack that times out
  // (0 = address, k = k-th data byte, -1 = none)
  task automatic send_transfer(input int nbytes, input int nack_at,
                               input logic [7:0] b_first, input logic [7:0] b_last);
    item_t it;
    int taken_n;
    bit started;
    int lim;
    taken_n = 0;
    started = 1'b0;
    while (!(started && bus_ph == BUS_IDLE && !abort_flag)) begin
      it.byte_offered = ($urandom_range(0, 7) == 0);
      it.payload_byte = 8'($urandom);
      it.payload_last = 1'($urandom);
      it.sda_sampled = 1'($urandom);
      lim = (cur_ack_limit == 0) ? 1 : cur_ack_limit;
      case (bus_ph)
        BUS_IDLE: begin
          if (abort_flag) begin
            // leftover bytes of an aborted transfer get discarded
            it.byte_offered = 1'b1;
            it.payload_last = (taken_n >= nbytes - 1);
            taken_n++;
          end else if (!started) begin
            it.byte_offered = ($urandom_range(0, 2) != 0);
            started = it.byte_offered;
          end
        end
        BUS_WAIT: begin
          it.byte_offered = 1'($urandom_range(0, 1));
          if (it.byte_offered) begin
            it.payload_last = (taken_n == nbytes - 1);
            if (taken_n == 0) it.payload_byte = b_first;
            else if (it.payload_last) it.payload_byte = b_last;
            taken_n++;
          end
        end
        BUS_ACK_POLL: begin
          if (taken_n == nack_at) it.sda_sampled = 1'b1;
          else it.sda_sampled = (ack_cnt + 1 < lim) && ($urandom_range(0, 1) == 1);
        end
        default: ;
      endcase
      send_tick(it);
    end
  endtask

  task automatic send_noise(input int n);
    item_t it;
    repeat (n) begin
      it = item_t'($urandom);
      send_tick(it);
    end
  endtask

  // bring the sequencer back to idle with a fast ack and a last byte
  task automatic finish_bus();
    item_t it;
    while (bus_ph != BUS_IDLE || abort_flag) begin
      it.byte_offered = (bus_ph == BUS_WAIT) || (bus_ph == BUS_IDLE);
      it.payload_byte = 8'($urandom);
      it.payload_last = 1'b1;
      it.sda_sampled = 1'b0;
      send_tick(it);
    end
  endtask

  // default timing: the first start phase must hold for the full reset length
  task automatic test_reset_values();
    item_t it;
    int i;
    it = item_t'($urandom);
    it.byte_offered = 1'b1;
    send_tick(it);
    for (i = 0; i < 255; i++) begin
      it = item_t'($urandom);
      send_tick(it);
    end
    wait_drained();
    cfg_write(REG_PHASE_TICKS, 1);
    finish_bus();
    wait_drained();
  endtask

  task automatic test_field_extremes();
    set_config(127, 1, 1);
    send_transfer(2, -1, 8'h00, 8'hFF);
    wait_drained();
    set_config(0, 1, 1);
    send_transfer(2, -1, 8'hFF, 8'h00);
    wait_drained();
  endtask

  task automatic test_zero_settings();
    set_config($urandom_range(0, 127), 0, 0);
    send_transfer(1, -1, 8'($urandom), 8'($urandom));
    send_transfer(2, 0, 8'($urandom), 8'($urandom));
    wait_drained();
  endtask

  task automatic test_nack_abort();
    set_config($urandom_range(0, 127), 1, 3);
    send_transfer(3, 0, 8'($urandom), 8'($urandom));
    send_transfer(3, 1, 8'($urandom), 8'($urandom));
    send_transfer(2, 2, 8'($urandom), 8'($urandom));
    wait_drained();
  endtask

  task automatic test_ack_limit_max();
    set_config($urandom_range(0, 127), 1, 255);
    send_transfer(2, 2, 8'($urandom), 8'($urandom));
    wait_drained();
  endtask

  // hold a start phase at the longest setting, then shorten it mid-transfer
  task automatic test_long_phase();
    item_t it;
    int i;
    set_config($urandom_range(0, 127), 65535, 2);
    tx_gaps_on = 1'b0;
    it = item_t'($urandom);
    it.byte_offered = 1'b1;
    send_tick(it);
    for (i = 0; i < 40; i++) begin
      it = item_t'($urandom);
      send_tick(it);
    end
    wait_drained();
    cfg_write(REG_PHASE_TICKS, 1);
    tx_gaps_on = 1'b1;
    finish_bus();
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_config($urandom_range(0, 127), 1, 4);
    hold_req = 300;
    send_transfer(3, -1, 8'($urandom), 8'($urandom));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int ticks_pt[4] = '{1, 2, 0, 3};
    int limits[4] = '{1, 5, 0, 255};
    int r;
    int round_start;
    int nbytes;
    for (r = 0; r < 4; r++) begin
      set_config($urandom_range(0, 127), ticks_pt[r], limits[r]);
      tx_gaps_on = (r != 1);
      rx_stalls_on = (r != 1);
      round_start = tick_count;
      while (tick_count - round_start < 40) begin
        if ($urandom_range(0, 6) == 0) begin
          send_noise($urandom_range(5, 20));
          finish_bus();
        end else begin
          nbytes = $urandom_range(1, 4);
          send_transfer(nbytes,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, nbytes) : -1,
                        8'($urandom), 8'($urandom));
        end
      end
      finish_bus();
      wait_drained();
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte_offered <= 1'b0;
    in_payload_byte <= '0;
    in_payload_last <= 1'b0;
    in_sda_sampled <= 1'b1;
    out_ready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_field_extremes();
    test_zero_settings();
    test_nack_abort();
    test_ack_limit_max();
    test_long_phase();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/i2cmw_pkg.sv
hdl/i2cmw_regs.sv
hdl/i2cmw_seq.sv
hdl/i2c_master_write_engine.sv
bench/testbench.sv
